// ===== design/rqps_pkg.sv =====
package rqps_pkg;

  localparam int DEPTH  = 16;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  localparam int CMD_W = 3;
  localparam int ID_W  = 8;
  localparam int PR_W  = 8;
  localparam int ST_W  = 2;
  localparam int OUT_CNT_W = 5;

  localparam logic [CMD_W-1:0] CMD_APPEND    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_HEAD  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_BEST  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_PEEK_BEST = 3'd4;
  localparam logic [CMD_W-1:0] CMD_REMOVE    = 3'd5;
  localparam logic [CMD_W-1:0] CMD_TEST      = 3'd6;
  localparam logic [CMD_W-1:0] CMD_NOP       = 3'd7;

  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY     = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL      = 2'd2;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [ID_W-1:0] id;
    logic [PR_W-1:0] pr;
  } ent_t;

  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    ent_t              wr_data;
  } ram_req_t;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [PR_W-1:0]  pr;
    logic [ST_W-1:0]  status;
    logic [CNT_W-1:0] count;
  } res_t;

endpackage

// ===== design/rqps_store.sv =====
module rqps_store (
  input  logic              clk,
  input  rqps_pkg::ram_req_t req,
  output rqps_pkg::ent_t    rd_data
);

  rqps_pkg::ent_t mem [rqps_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

// ===== design/rqps_ctrl.sv =====
module rqps_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [rqps_pkg::CMD_W-1:0]    in_cmd,
  input  logic [rqps_pkg::ID_W-1:0]     in_id,
  input  logic [rqps_pkg::PR_W-1:0]     in_pr,
  input  logic                          res_ready,
  output logic                          done,
  output rqps_pkg::res_t                res,
  output rqps_pkg::ram_req_t            ram_req,
  input  rqps_pkg::ent_t                rd_data
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_SCAN   = 4'd2;
  localparam logic [3:0] S_HEAD   = 4'd3;
  localparam logic [3:0] S_DROP0  = 4'd4;
  localparam logic [3:0] S_DROP   = 4'd5;
  localparam logic [3:0] S_SHIFT0 = 4'd6;
  localparam logic [3:0] S_SHIFT  = 4'd7;
  localparam logic [3:0] S_PLACE  = 4'd8;
  localparam logic [3:0] S_FINISH = 4'd9;

  localparam int AW = rqps_pkg::ADDR_W;
  localparam int CW = rqps_pkg::CNT_W;

  logic [3:0]                     state, state_next;
  logic [rqps_pkg::CMD_W-1:0]     cmd;
  logic [rqps_pkg::ID_W-1:0]      id;
  logic [rqps_pkg::PR_W-1:0]      pr;
  logic [AW-1:0]                  idx, idx_next;
  logic [AW-1:0]                  mark, mark_next;
  rqps_pkg::ent_t                 best, best_next;
  logic [CW-1:0]                  count, count_next;
  logic [rqps_pkg::ID_W-1:0]      res_id, res_id_next;
  logic [rqps_pkg::PR_W-1:0]      res_pr, res_pr_next;
  logic [rqps_pkg::ST_W-1:0]      res_st, res_st_next;

  logic          full, empty, at_last, better;
  logic [CW-1:0] idx_ext;
  logic [AW-1:0] sel_idx;
  rqps_pkg::ent_t sel_ent;

  assign in_ready = (state == S_IDLE);
  assign done     = (state == S_FINISH);
  assign res      = '{id: res_id, pr: res_pr, status: res_st, count: count};

  assign full    = (count == CW'(rqps_pkg::DEPTH));
  assign empty   = (count == '0);
  assign idx_ext = CW'(idx);
  assign at_last = ((idx_ext + CW'(1)) == count);
  // earliest entry with the lowest number wins, so replace only on strictly lower
  assign better  = (idx == '0) || (rd_data.pr < best.pr);
  assign sel_idx = better ? idx : mark;
  assign sel_ent = better ? rd_data : best;

  always_comb begin
    state_next  = state;
    idx_next    = idx;
    mark_next   = mark;
    best_next   = best;
    count_next  = count;
    res_id_next = res_id;
    res_pr_next = res_pr;
    res_st_next = res_st;
    ram_req     = '0;
    ram_req.wr_data = '{id: id, pr: pr};

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        res_id_next = '0;
        res_pr_next = '0;
        res_st_next = rqps_pkg::ST_OK;
        idx_next    = '0;
        state_next  = S_FINISH;
        case (cmd)
          rqps_pkg::CMD_APPEND, rqps_pkg::CMD_INSERT: begin
            if (full) begin
              res_st_next = rqps_pkg::ST_FULL;
            end else if (cmd == rqps_pkg::CMD_APPEND || empty) begin
              ram_req.wr_en   = 1'b1;
              ram_req.wr_addr = AW'(count);
              count_next      = count + CW'(1);
            end else begin
              ram_req.rd_en = 1'b1;
              state_next    = S_SCAN;
            end
          end
          rqps_pkg::CMD_POP_HEAD, rqps_pkg::CMD_POP_BEST, rqps_pkg::CMD_PEEK_BEST: begin
            if (empty) begin
              res_st_next = rqps_pkg::ST_EMPTY;
            end else begin
              ram_req.rd_en = 1'b1;
              state_next = (cmd == rqps_pkg::CMD_POP_HEAD) ? S_HEAD : S_SCAN;
            end
          end
          rqps_pkg::CMD_REMOVE, rqps_pkg::CMD_TEST: begin
            if (empty) begin
              res_st_next = rqps_pkg::ST_NOT_FOUND;
            end else begin
              ram_req.rd_en = 1'b1;
              state_next    = S_SCAN;
            end
          end
          default: ;
        endcase
      end
      S_SCAN: begin
        // read data here belongs to slot idx; prefetch the next slot
        ram_req.rd_addr = idx + AW'(1);
        case (cmd)
          rqps_pkg::CMD_INSERT: begin
            if (rd_data.pr > pr) begin
              mark_next  = idx;
              state_next = S_SHIFT0;
            end else if (at_last) begin
              ram_req.wr_en   = 1'b1;
              ram_req.wr_addr = AW'(count);
              count_next      = count + CW'(1);
              state_next      = S_FINISH;
            end else begin
              ram_req.rd_en = 1'b1;
              idx_next      = idx + AW'(1);
            end
          end
          rqps_pkg::CMD_POP_BEST, rqps_pkg::CMD_PEEK_BEST: begin
            mark_next = sel_idx;
            best_next = sel_ent;
            if (at_last) begin
              res_id_next = sel_ent.id;
              res_pr_next = sel_ent.pr;
              state_next  = (cmd == rqps_pkg::CMD_PEEK_BEST) ? S_FINISH : S_DROP0;
            end else begin
              ram_req.rd_en = 1'b1;
              idx_next      = idx + AW'(1);
            end
          end
          default: begin
            if (rd_data.id == id) begin
              mark_next  = idx;
              state_next = (cmd == rqps_pkg::CMD_REMOVE) ? S_DROP0 : S_FINISH;
            end else if (at_last) begin
              res_st_next = rqps_pkg::ST_NOT_FOUND;
              state_next  = S_FINISH;
            end else begin
              ram_req.rd_en = 1'b1;
              idx_next      = idx + AW'(1);
            end
          end
        endcase
      end
      S_HEAD: begin
        res_id_next = rd_data.id;
        res_pr_next = rd_data.pr;
        mark_next   = '0;
        state_next  = S_DROP0;
      end
      S_DROP0: begin
        if ((CW'(mark) + CW'(1)) == count) begin
          count_next = count - CW'(1);
          state_next = S_FINISH;
        end else begin
          ram_req.rd_en   = 1'b1;
          ram_req.rd_addr = mark + AW'(1);
          idx_next        = mark;
          state_next      = S_DROP;
        end
      end
      S_DROP: begin
        // move slot idx+1 down into slot idx
        ram_req.wr_en   = 1'b1;
        ram_req.wr_addr = idx;
        ram_req.wr_data = rd_data;
        if ((idx_ext + CW'(2)) < count) begin
          ram_req.rd_en   = 1'b1;
          ram_req.rd_addr = idx + AW'(2);
          idx_next        = idx + AW'(1);
        end else begin
          count_next = count - CW'(1);
          state_next = S_FINISH;
        end
      end
      S_SHIFT0: begin
        ram_req.rd_en   = 1'b1;
        ram_req.rd_addr = AW'(count - CW'(1));
        idx_next        = AW'(count - CW'(1));
        state_next      = S_SHIFT;
      end
      S_SHIFT: begin
        // move slot idx up into slot idx+1, walking toward the insert point
        ram_req.wr_en   = 1'b1;
        ram_req.wr_addr = idx + AW'(1);
        ram_req.wr_data = rd_data;
        if (idx == mark) begin
          state_next = S_PLACE;
        end else begin
          ram_req.rd_en   = 1'b1;
          ram_req.rd_addr = idx - AW'(1);
          idx_next        = idx - AW'(1);
        end
      end
      S_PLACE: begin
        ram_req.wr_en   = 1'b1;
        ram_req.wr_addr = mark;
        count_next      = count + CW'(1);
        state_next      = S_FINISH;
      end
      S_FINISH: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
    if (state == S_IDLE && in_valid) begin
      cmd <= in_cmd;
      id  <= in_id;
      pr  <= in_pr;
    end
    idx    <= idx_next;
    mark   <= mark_next;
    best   <= best_next;
    res_id <= res_id_next;
    res_pr <= res_pr_next;
    res_st <= res_st_next;
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(rqps_pkg::DEPTH))
    else $error("entry count beyond depth");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (count != $past(count)) |->
      (count == $past(count) + CW'(1) || count == $past(count) - CW'(1)))
    else $error("entry count moved by more than one");

  a_write_in_list: assert property (@(posedge clk) disable iff (rst)
    ram_req.wr_en |-> (CW'(ram_req.wr_addr) <= count))
    else $error("slot write past the tail");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (done && res.status == rqps_pkg::ST_FULL) |-> full)
    else $error("full status on a list with room");

  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    (done && res.status == rqps_pkg::ST_EMPTY) |-> empty)
    else $error("empty status on a list with entries");

endmodule

// ===== design/ready_queue_priority_scheduler_top.sv =====
// Ready-queue scheduler: up to 16 (id, priority) entries, lower priority number
// more urgent, slot 0 the head.
// Input channel (s_*): one word per command. s_tuser carries the command
// (append, insert by priority, pop head, pop best, peek best, remove id,
// test id, no-op); s_tdata carries the process id and the priority.
// Output channel (m_*): exactly one word per command, in command order.
// m_tuser carries the status (ok, empty, full, id not found); m_tdata carries
// the popped or peeked entry (zero otherwise) and the entry count afterwards.
// Timing: a sequencer walks one slot memory a slot per cycle. Append, no-op and
// errors need no walk; peek best and test scan the list, remove scans and then
// closes the gap, pop head reads the head and closes the gap, insert scans and
// then shifts the tail up, and pop best makes a full scan and then closes the
// gap. s_tready rises in the cycle after the word leaves the sequencer.
// The result lands in an output register; the next command is taken while
// that word still waits. If the receiver stalls, the following result holds
// inside the sequencer and no further command is taken.
// Reset empties the list at once; slot contents need no clearing.
module ready_queue_priority_scheduler_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [7:0] process_id, [15:8] priority_req
  input  logic [2:0]  s_tuser,   // [2:0] command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [7:0] out_process_id, [15:8] out_priority,
                                 // [20:16] entry_count, [23:21] zero
  output logic [1:0]  m_tuser    // [1:0] status
);

  rqps_pkg::ram_req_t ram_req;
  rqps_pkg::ent_t     rd_data;
  rqps_pkg::res_t     res;
  logic               done;
  logic               out_free;

  // the output register can take a word when empty or draining this cycle
  assign out_free = !m_tvalid || m_tready;

  rqps_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_cmd    (s_tuser),
    .in_id     (s_tdata[7:0]),
    .in_pr     (s_tdata[15:8]),
    .res_ready (out_free),
    .done      (done),
    .res       (res),
    .ram_req   (ram_req),
    .rd_data   (rd_data)
  );

  rqps_store u_store (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (rd_data)
  );

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= done;
    end
    if (out_free && done) begin
      m_tdata <= {3'b000, rqps_pkg::OUT_CNT_W'(res.count), res.pr, res.id};
      m_tuser <= res.status;
    end
  end

endmodule
